/* hdl/mkdlp_pkg.sv */
// Shared types, codes and constants for the multi-key debounce and long-press qualifier.
package mkdlp_pkg;

    localparam int NUM_KEYS_DEF   = 4;
    localparam int TICK_WIDTH_DEF = 32;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;
    localparam int MASK_W     = 16;
    localparam int STEP_W     = 7;

    localparam logic [1:0] CMD_SCAN     = 2'd0;
    localparam logic [1:0] CMD_RD_SHORT = 2'd1;
    localparam logic [1:0] CMD_RD_LONG  = 2'd2;

    localparam logic [1:0] IDLE_RECENT = 2'd0;
    localparam logic [1:0] IDLE_LONG   = 2'd1;
    localparam logic [1:0] IDLE_SHORT  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIER1      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TIER2      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TIER3      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_LONG  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_IDLE_SHORT = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_KEY_MASKS  = 3'd6;

    localparam logic [15:0] READ_FAIL      = 16'hFFFF;
    localparam logic [15:0] ERR_CLEAR_BITS = 16'h00CC;

    localparam logic [STEP_W-1:0] STEP_ONE     = 7'd1;
    localparam logic [STEP_W-1:0] STEP_TEN     = 7'd10;
    localparam logic [STEP_W-1:0] STEP_HUNDRED = 7'd100;
    localparam logic [STEP_W-1:0] STEP_NONE    = 7'd0;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [31:0] TIER1_RST      = 32'd1000;
    localparam logic [31:0] TIER2_RST      = 32'd2000;
    localparam logic [31:0] TIER3_RST      = 32'd3000;
    localparam logic [31:0] IDLE_LONG_RST  = 32'd10000;
    localparam logic [31:0] IDLE_SHORT_RST = 32'd5000;
    localparam logic [63:0] KEY_MASKS_RST  = 64'h0080_0040_0008_0004;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESS_DB,
        PH_PRESSED,
        PH_RELEASE_DB
    } phase_t;

    typedef struct packed {
        logic [15:0] debounce;
        logic [31:0] tier1;
        logic [31:0] tier2;
        logic [31:0] tier3;
        logic [31:0] idle_long;
        logic [31:0] idle_short;
        logic [63:0] key_masks;
    } cfg_t;

    typedef struct packed {
        logic scan;
        logic down;
        logic clr_short;
        logic clr_long;
    } key_ctl_t;

    typedef struct packed {
        logic              action;
        logic              short_pend;
        logic              long_pend;
        logic [STEP_W-1:0] step;
    } key_stat_t;

endpackage

/* hdl/multi_key_debounce_long_press_top.sv */
// Top level: input and result registers, key array, idle timer and error flag.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_tvalid / s_tready    s_tdata: cmd, scan_word, tick_now, key_index
// m_axis    out  m_tvalid / m_tready    m_tdata: flag_value, step_amount, idle_status,
//                                                device_error
// cfg       in   cfg_wr_en              cfg_addr, cfg_wr_data
//
// One transaction per cycle unless m_tready stalls; path: input, then result register.
// The input register feeds all key machines, the idle timer and the error flag,
// which update together with the result register in the same cycle.
// Reset idles key machines (step one), sets idle status long, clears error/valid flags.
// A stall on m_tready holds the result; one more transaction waits in the input register.
module multi_key_debounce_long_press_top #(
    parameter int NUM_KEYS   = mkdlp_pkg::NUM_KEYS_DEF,
    parameter int TICK_WIDTH = mkdlp_pkg::TICK_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] cmd, [17:2] scan_word, [49:18] tick_now, [51:50] key_index
    input  logic [mkdlp_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] flag_value, [7:1] step_amount, [9:8] idle_status, [10] device_error
    output logic [mkdlp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [mkdlp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mkdlp_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int CW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    mkdlp_pkg::cfg_t                   cfg;

    logic                              in_v_reg;
    logic [1:0]                        in_cmd_reg;
    logic [15:0]                       in_status_reg;
    logic [31:0]                       in_tick_reg;
    logic [1:0]                        in_key_reg;

    logic                              out_v_reg;
    logic                              out_flag_reg;
    logic [mkdlp_pkg::STEP_W-1:0]      out_step_reg;
    logic [1:0]                        out_idle_reg;
    logic                              out_err_reg;

    logic [TICK_WIDTH-1:0]             last_action_reg, last_action_next;
    logic [1:0]                        idle_reg, idle_next;
    logic                              err_reg, err_next;

    logic                              adv;
    logic                              scan_ok;
    logic [TICK_WIDTH-1:0]             now;
    logic [TICK_WIDTH-1:0]             idle_age;
    logic                              any_action;
    logic                              sel_valid;
    logic                              flag_sel;
    logic [mkdlp_pkg::STEP_W-1:0]      step_sel;

    mkdlp_pkg::key_ctl_t               key_ctl  [NUM_KEYS];
    mkdlp_pkg::key_stat_t              key_stat [NUM_KEYS];

    mkdlp_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    assign adv      = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready = !in_v_reg || adv;
    assign now      = TICK_WIDTH'(in_tick_reg);
    assign scan_ok  = adv && in_cmd_reg == mkdlp_pkg::CMD_SCAN
                      && in_status_reg != mkdlp_pkg::READ_FAIL;
    assign idle_age = now - last_action_reg;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        logic [mkdlp_pkg::MASK_W-1:0] mask;
        logic                         sel_hit;

        assign mask    = cfg.key_masks[mkdlp_pkg::MASK_W * (k % 4) +: mkdlp_pkg::MASK_W];
        assign sel_hit = 32'(in_key_reg) == 32'(k);

        assign key_ctl[k].scan      = scan_ok;
        assign key_ctl[k].down      = (in_status_reg & mask) == mask;
        assign key_ctl[k].clr_short = adv && sel_hit && in_cmd_reg == mkdlp_pkg::CMD_RD_SHORT;
        assign key_ctl[k].clr_long  = adv && sel_hit && in_cmd_reg == mkdlp_pkg::CMD_RD_LONG;

        mkdlp_key #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_key
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (key_ctl[k]),
            .now   (now),
            .cfg   (cfg),
            .stat  (key_stat[k])
        );
    end

    always_comb
    begin
        any_action = 1'b0;
        sel_valid  = 1'b0;
        flag_sel   = 1'b0;
        step_sel   = mkdlp_pkg::STEP_NONE;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            any_action = any_action | key_stat[k].action;
            if (32'(in_key_reg) == 32'(k))
            begin
                sel_valid = 1'b1;
                step_sel  = key_stat[k].step;
                case (in_cmd_reg)
                    mkdlp_pkg::CMD_RD_SHORT: flag_sel = key_stat[k].short_pend;
                    mkdlp_pkg::CMD_RD_LONG:  flag_sel = key_stat[k].long_pend;
                    default:                 flag_sel = 1'b0;
                endcase
            end
        end
    end

    always_comb
    begin
        last_action_next = last_action_reg;
        idle_next        = idle_reg;
        err_next         = err_reg;
        if (adv && in_cmd_reg == mkdlp_pkg::CMD_SCAN)
        begin
            if (in_status_reg == mkdlp_pkg::READ_FAIL)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if ((in_status_reg & mkdlp_pkg::ERR_CLEAR_BITS) != 16'd0)
                begin
                    err_next = 1'b0;
                end
                if (any_action)
                begin
                    last_action_next = now;
                    idle_next        = mkdlp_pkg::IDLE_RECENT;
                end
                else if (CW'(idle_age) >= CW'(cfg.idle_long))
                begin
                    idle_next = mkdlp_pkg::IDLE_LONG;
                end
                else if (CW'(idle_age) >= CW'(cfg.idle_short))
                begin
                    idle_next = mkdlp_pkg::IDLE_SHORT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg        <= 1'b0;
            out_v_reg       <= 1'b0;
            last_action_reg <= '0;
            idle_reg        <= mkdlp_pkg::IDLE_LONG;
            err_reg         <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_v_reg <= s_tvalid;
            end
            if (adv)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            last_action_reg <= last_action_next;
            idle_reg        <= idle_next;
            err_reg         <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg    <= s_tdata[1:0];
            in_status_reg <= s_tdata[17:2];
            in_tick_reg   <= s_tdata[49:18];
            in_key_reg    <= s_tdata[51:50];
        end
        if (adv)
        begin
            out_flag_reg <= sel_valid & flag_sel;
            out_step_reg <= sel_valid ? step_sel : mkdlp_pkg::STEP_NONE;
            out_idle_reg <= idle_next;
            out_err_reg  <= err_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, out_err_reg, out_idle_reg, out_step_reg, out_flag_reg};

    a_fail_sets_error: assert property (@(posedge clk) disable iff (!rst_n)
        adv && in_cmd_reg == mkdlp_pkg::CMD_SCAN && in_status_reg == mkdlp_pkg::READ_FAIL
            |=> err_reg && out_err_reg)
        else $error("failed scan did not flag device error");

    a_adv_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_v_reg)
        else $error("processed transaction lost before result register");

    a_action_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        scan_ok && any_action
            |=> idle_reg == mkdlp_pkg::IDLE_RECENT && last_action_reg == $past(now))
        else $error("key action did not restart idle timer");

    a_held_input_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !adv |=> in_v_reg && $stable(in_tick_reg) && $stable(in_cmd_reg))
        else $error("waiting input transaction changed");

endmodule

/* hdl/mkdlp_cfg.sv */
// Configuration register file with write decode.
module mkdlp_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mkdlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mkdlp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output mkdlp_pkg::cfg_t                    cfg
);

    mkdlp_pkg::cfg_t cfg_reg;
    mkdlp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                mkdlp_pkg::REG_DEBOUNCE:   cfg_next.debounce   = cfg_wr_data[15:0];
                mkdlp_pkg::REG_TIER1:      cfg_next.tier1      = cfg_wr_data[31:0];
                mkdlp_pkg::REG_TIER2:      cfg_next.tier2      = cfg_wr_data[31:0];
                mkdlp_pkg::REG_TIER3:      cfg_next.tier3      = cfg_wr_data[31:0];
                mkdlp_pkg::REG_IDLE_LONG:  cfg_next.idle_long  = cfg_wr_data[31:0];
                mkdlp_pkg::REG_IDLE_SHORT: cfg_next.idle_short = cfg_wr_data[31:0];
                mkdlp_pkg::REG_KEY_MASKS:  cfg_next.key_masks  = cfg_wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= mkdlp_pkg::DEBOUNCE_RST;
            cfg_reg.tier1      <= mkdlp_pkg::TIER1_RST;
            cfg_reg.tier2      <= mkdlp_pkg::TIER2_RST;
            cfg_reg.tier3      <= mkdlp_pkg::TIER3_RST;
            cfg_reg.idle_long  <= mkdlp_pkg::IDLE_LONG_RST;
            cfg_reg.idle_short <= mkdlp_pkg::IDLE_SHORT_RST;
            cfg_reg.key_masks  <= mkdlp_pkg::KEY_MASKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mkdlp_key.sv */
// Per-key debounce and long-press state machine with pending flags and step.
module mkdlp_key #(
    parameter int TICK_WIDTH = mkdlp_pkg::TICK_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mkdlp_pkg::key_ctl_t   ctl,
    input  logic [TICK_WIDTH-1:0] now,
    input  mkdlp_pkg::cfg_t       cfg,
    output mkdlp_pkg::key_stat_t  stat
);

    localparam int CW = (TICK_WIDTH > 32) ? TICK_WIDTH : 32;

    mkdlp_pkg::phase_t                  phase_reg, phase_next;
    logic [TICK_WIDTH-1:0]              db_stamp_reg, db_stamp_next;
    logic [TICK_WIDTH-1:0]              press_stamp_reg, press_stamp_next;
    logic                               long_seen_reg, long_seen_next;
    logic [mkdlp_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                               short_reg, short_next;
    logic                               long_reg, long_next;
    logic                               action;

    logic [TICK_WIDTH-1:0]              db_age;
    logic [TICK_WIDTH-1:0]              hold_age;
    logic                               db_done;
    logic [mkdlp_pkg::STEP_W-1:0]       tier_step;

    assign db_age   = now - db_stamp_reg;
    assign hold_age = now - press_stamp_reg;
    assign db_done  = CW'(db_age) >= CW'(cfg.debounce);

    always_comb
    begin
        if (CW'(hold_age) >= CW'(cfg.tier3))
        begin
            tier_step = mkdlp_pkg::STEP_HUNDRED;
        end
        else if (CW'(hold_age) >= CW'(cfg.tier2))
        begin
            tier_step = mkdlp_pkg::STEP_TEN;
        end
        else if (CW'(hold_age) >= CW'(cfg.tier1))
        begin
            tier_step = mkdlp_pkg::STEP_ONE;
        end
        else
        begin
            tier_step = mkdlp_pkg::STEP_NONE;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        db_stamp_next    = db_stamp_reg;
        press_stamp_next = press_stamp_reg;
        long_seen_next   = long_seen_reg;
        step_next        = step_reg;
        short_next       = short_reg;
        long_next        = long_reg;
        action           = 1'b0;
        if (ctl.scan)
        begin
            unique case (phase_reg)
                mkdlp_pkg::PH_IDLE:
                begin
                    if (ctl.down)
                    begin
                        phase_next     = mkdlp_pkg::PH_PRESS_DB;
                        db_stamp_next  = now;
                        long_seen_next = 1'b0;
                    end
                end
                mkdlp_pkg::PH_PRESS_DB:
                begin
                    if (!ctl.down)
                    begin
                        phase_next = mkdlp_pkg::PH_IDLE;
                    end
                    else if (db_done)
                    begin
                        phase_next       = mkdlp_pkg::PH_PRESSED;
                        press_stamp_next = now;
                    end
                end
                mkdlp_pkg::PH_PRESSED:
                begin
                    if (!ctl.down)
                    begin
                        phase_next    = mkdlp_pkg::PH_RELEASE_DB;
                        db_stamp_next = now;
                    end
                    else if (tier_step != mkdlp_pkg::STEP_NONE)
                    begin
                        step_next      = tier_step;
                        long_next      = 1'b1;
                        long_seen_next = 1'b1;
                        action         = 1'b1;
                    end
                end
                mkdlp_pkg::PH_RELEASE_DB:
                begin
                    if (ctl.down)
                    begin
                        phase_next = mkdlp_pkg::PH_PRESSED;
                    end
                    else if (db_done)
                    begin
                        if (!long_seen_reg)
                        begin
                            short_next = 1'b1;
                            step_next  = mkdlp_pkg::STEP_ONE;
                            action     = 1'b1;
                        end
                        phase_next = mkdlp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = mkdlp_pkg::PH_IDLE;
                end
            endcase
        end
        else
        begin
            if (ctl.clr_short)
            begin
                short_next = 1'b0;
            end
            if (ctl.clr_long)
            begin
                long_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= mkdlp_pkg::PH_IDLE;
            db_stamp_reg    <= '0;
            press_stamp_reg <= '0;
            long_seen_reg   <= 1'b0;
            step_reg        <= mkdlp_pkg::STEP_ONE;
            short_reg       <= 1'b0;
            long_reg        <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            db_stamp_reg    <= db_stamp_next;
            press_stamp_reg <= press_stamp_next;
            long_seen_reg   <= long_seen_next;
            step_reg        <= step_next;
            short_reg       <= short_next;
            long_reg        <= long_next;
        end
    end

    assign stat.action     = action;
    assign stat.short_pend = short_reg;
    assign stat.long_pend  = long_reg;
    assign stat.step       = step_next;

    a_long_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan && phase_reg == mkdlp_pkg::PH_PRESSED && ctl.down
            && tier_step != mkdlp_pkg::STEP_NONE |=> long_seen_reg && long_reg)
        else $error("long press did not mark key");

    a_short_only_after_release: assert property (@(posedge clk) disable iff (!rst_n)
        !short_reg ##1 short_reg |-> $past(phase_reg) == mkdlp_pkg::PH_RELEASE_DB)
        else $error("short flag set outside release debounce");

    a_clear_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.scan && (ctl.clr_long || ctl.clr_short) |=> $stable(phase_reg))
        else $error("read command moved key phase");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the four-key debounce and long-press qualifier.
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0]                   pad;
        logic                         dev_err;
        logic [1:0]                   idle;
        logic [mkdlp_pkg::STEP_W-1:0] step;
        logic                         flag;
    } report_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mkdlp_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mkdlp_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             cfg_wr_en = 1'b0;
    logic [mkdlp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [mkdlp_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    // predicted block state and register copy
    mkdlp_pkg::cfg_t              cfg_now;
    mkdlp_pkg::phase_t            key_phase [mkdlp_pkg::NUM_KEYS_DEF];
    logic [31:0]                  debounce_mark [mkdlp_pkg::NUM_KEYS_DEF];
    logic [31:0]                  hold_mark [mkdlp_pkg::NUM_KEYS_DEF];
    logic                         long_hit [mkdlp_pkg::NUM_KEYS_DEF];
    logic [mkdlp_pkg::STEP_W-1:0] key_step [mkdlp_pkg::NUM_KEYS_DEF];
    logic                         short_latch [mkdlp_pkg::NUM_KEYS_DEF];
    logic                         long_latch [mkdlp_pkg::NUM_KEYS_DEF];
    logic [31:0]                  action_mark;
    logic [1:0]                   idle_now;
    logic                         error_now;

    report_t     expected_reports [$];
    report_t     want_rsp;
    report_t     got_rsp;
    int          failures = 0;
    int          ready_hold = 0;
    bit          calm = 1'b0;
    logic [3:0]  keys_down = '0;
    logic [31:0] tick_now = '0;

    always #6 clk = ~clk;

    multi_key_debounce_long_press_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [31:0] rand_upto(input logic [63:0] lim);
        if (lim > 64'hFFFF_FFFF)
            return $urandom;
        return $urandom_range(0, lim[31:0]);
    endfunction

    function automatic logic [31:0] next_advance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return rand_upto(64'(cfg_now.debounce) * 2 + 2);
        if (r < 88)
            return rand_upto(64'(cfg_now.tier3) / 3 + 1);
        if (r < 98)
            return rand_upto(64'(cfg_now.idle_long) / 3 + 1);
        return $urandom;
    endfunction

    function automatic report_t qualify_item(input logic [1:0] cmd, input logic [15:0] status,
                                             input logic [31:0] tick, input logic [1:0] idx);
        report_t                      r;
        logic [15:0]                  mask;
        logic                         down;
        logic                         action;
        logic [31:0]                  since;
        logic [mkdlp_pkg::STEP_W-1:0] tier_step;
        r = '0;
        action = 1'b0;
        case (cmd)
            mkdlp_pkg::CMD_SCAN:
            begin
                if (status == mkdlp_pkg::READ_FAIL)
                    error_now = 1'b1;
                else
                begin
                    if ((status & mkdlp_pkg::ERR_CLEAR_BITS) != 16'd0)
                        error_now = 1'b0;
                    for (int k = 0; k < mkdlp_pkg::NUM_KEYS_DEF; k++)
                    begin
                        mask = cfg_now.key_masks[16*k +: 16];
                        down = ((status & mask) == mask);
                        case (key_phase[k])
                            mkdlp_pkg::PH_IDLE:
                            begin
                                if (down)
                                begin
                                    key_phase[k] = mkdlp_pkg::PH_PRESS_DB;
                                    debounce_mark[k] = tick;
                                    long_hit[k] = 1'b0;
                                end
                            end
                            mkdlp_pkg::PH_PRESS_DB:
                            begin
                                since = tick - debounce_mark[k];
                                if (!down)
                                    key_phase[k] = mkdlp_pkg::PH_IDLE;
                                else if (since >= 32'(cfg_now.debounce))
                                begin
                                    key_phase[k] = mkdlp_pkg::PH_PRESSED;
                                    hold_mark[k] = tick;
                                end
                            end
                            mkdlp_pkg::PH_PRESSED:
                            begin
                                if (!down)
                                begin
                                    key_phase[k] = mkdlp_pkg::PH_RELEASE_DB;
                                    debounce_mark[k] = tick;
                                end
                                else
                                begin
                                    since = tick - hold_mark[k];
                                    tier_step = mkdlp_pkg::STEP_NONE;
                                    if (since >= cfg_now.tier3)
                                        tier_step = mkdlp_pkg::STEP_HUNDRED;
                                    else if (since >= cfg_now.tier2)
                                        tier_step = mkdlp_pkg::STEP_TEN;
                                    else if (since >= cfg_now.tier1)
                                        tier_step = mkdlp_pkg::STEP_ONE;
                                    if (tier_step != mkdlp_pkg::STEP_NONE)
                                    begin
                                        key_step[k] = tier_step;
                                        long_latch[k] = 1'b1;
                                        long_hit[k] = 1'b1;
                                        action = 1'b1;
                                    end
                                end
                            end
                            default:
                            begin
                                since = tick - debounce_mark[k];
                                if (down)
                                    key_phase[k] = mkdlp_pkg::PH_PRESSED;
                                else if (since >= 32'(cfg_now.debounce))
                                begin
                                    if (!long_hit[k])
                                    begin
                                        short_latch[k] = 1'b1;
                                        key_step[k] = mkdlp_pkg::STEP_ONE;
                                        action = 1'b1;
                                    end
                                    key_phase[k] = mkdlp_pkg::PH_IDLE;
                                end
                            end
                        endcase
                    end
                    since = tick - action_mark;
                    if (action)
                    begin
                        action_mark = tick;
                        idle_now = mkdlp_pkg::IDLE_RECENT;
                    end
                    else if (since >= cfg_now.idle_long)
                        idle_now = mkdlp_pkg::IDLE_LONG;
                    else if (since >= cfg_now.idle_short)
                        idle_now = mkdlp_pkg::IDLE_SHORT;
                end
            end
            mkdlp_pkg::CMD_RD_SHORT:
            begin
                r.flag = short_latch[idx];
                short_latch[idx] = 1'b0;
            end
            mkdlp_pkg::CMD_RD_LONG:
            begin
                r.flag = long_latch[idx];
                long_latch[idx] = 1'b0;
            end
            default:
                ;
        endcase
        r.step = key_step[idx];
        r.idle = idle_now;
        r.dev_err = error_now;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ERROR %s expected %0h actual %0h", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_rsp = report_t'(m_tdata);
            if (expected_reports.size() == 0)
            begin
                $display("%0t ERROR result with none expected, expected none actual %0h",
                         $time, m_tdata);
                failures++;
            end
            else
            begin
                want_rsp = expected_reports.pop_front();
                check_field("flag_value", want_rsp.flag, got_rsp.flag);
                check_field("step_amount", want_rsp.step, got_rsp.step);
                check_field("idle_status", want_rsp.idle, got_rsp.idle);
                check_field("device_error", want_rsp.dev_err, got_rsp.dev_err);
                check_field("padding", want_rsp.pad, got_rsp.pad);
            end
        end
        if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold--;
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] status,
                             input logic [31:0] tick, input logic [1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, idx, tick, status, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        expected_reports.push_back(qualify_item(cmd, status, tick, idx));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input mkdlp_pkg::cfg_t c);
        logic [mkdlp_pkg::CFG_ADDR_W-1:0] a;
        logic [mkdlp_pkg::CFG_DATA_W-1:0] d;
        drain();
        for (int i = 0; i < 8; i++)
        begin
            a = i[mkdlp_pkg::CFG_ADDR_W-1:0];
            case (a)
                mkdlp_pkg::REG_DEBOUNCE:   d = {$urandom, 16'($urandom), c.debounce};
                mkdlp_pkg::REG_TIER1:      d = {$urandom, c.tier1};
                mkdlp_pkg::REG_TIER2:      d = {$urandom, c.tier2};
                mkdlp_pkg::REG_TIER3:      d = {$urandom, c.tier3};
                mkdlp_pkg::REG_IDLE_LONG:  d = {$urandom, c.idle_long};
                mkdlp_pkg::REG_IDLE_SHORT: d = {$urandom, c.idle_short};
                mkdlp_pkg::REG_KEY_MASKS:  d = c.key_masks;
                default:                   d = {$urandom, $urandom};
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= a;
            cfg_wr_data <= d;
            @(posedge clk);
            case (a)
                mkdlp_pkg::REG_DEBOUNCE:   cfg_now.debounce   = d[15:0];
                mkdlp_pkg::REG_TIER1:      cfg_now.tier1      = d[31:0];
                mkdlp_pkg::REG_TIER2:      cfg_now.tier2      = d[31:0];
                mkdlp_pkg::REG_TIER3:      cfg_now.tier3      = d[31:0];
                mkdlp_pkg::REG_IDLE_LONG:  cfg_now.idle_long  = d[31:0];
                mkdlp_pkg::REG_IDLE_SHORT: cfg_now.idle_short = d[31:0];
                mkdlp_pkg::REG_KEY_MASKS:  cfg_now.key_masks  = d;
                default:                   ;
            endcase
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_traffic(input int count);
        int          r;
        logic [15:0] status;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                if ($urandom_range(0, 5) == 0)
                    keys_down[$urandom_range(0, 3)] ^= 1'b1;
                tick_now += next_advance();
                status = '0;
                for (int k = 0; k < mkdlp_pkg::NUM_KEYS_DEF; k++)
                    if (keys_down[k])
                        status |= cfg_now.key_masks[16*k +: 16];
                r = $urandom_range(0, 99);
                if (r < 12)
                    status |= 16'($urandom);
                else if (r < 15)
                    status = mkdlp_pkg::READ_FAIL;
                else if (r < 19)
                    status = 16'($urandom);
                else if (r < 23)
                    status ^= 16'(1 << $urandom_range(0, 15));
                send_item(mkdlp_pkg::CMD_SCAN, status, tick_now, 2'($urandom));
            end
            else if (r < 96)
                send_item(2'($urandom_range(1, 2)), 16'($urandom), $urandom, 2'($urandom));
            else
                send_item(CMD_UNUSED, 16'($urandom), $urandom, 2'($urandom));
        end
        calm = 1'b0;
    endtask

    function automatic logic [15:0] sparse_mask();
        logic [15:0] m;
        m = 16'(1 << $urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1)
            m |= 16'(1 << $urandom_range(0, 15));
        return m;
    endfunction

    task automatic run_directed();
        send_item(mkdlp_pkg::CMD_RD_SHORT, 16'h0000, 32'd0, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, mkdlp_pkg::READ_FAIL, 32'd0, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd10, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0004, 32'd100, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0004, 32'd120, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0004, 32'd1120, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0004, 32'd2120, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0004, 32'd3120, 2'd0);
        send_item(mkdlp_pkg::CMD_RD_LONG, 16'hFFFF, 32'hFFFF_FFFF, 2'd0);
        send_item(mkdlp_pkg::CMD_RD_LONG, 16'h0000, 32'd0, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd3130, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd3150, 2'd0);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0008, 32'd3200, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0008, 32'd3220, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd3230, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0008, 32'd3235, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd3240, 2'd1);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd3260, 2'd1);
        send_item(mkdlp_pkg::CMD_RD_SHORT, 16'h0000, 32'd0, 2'd1);
        send_item(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 2'd3);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd8260, 2'd2);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0000, 32'd13260, 2'd2);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0080, 32'hFFFF_FFF0, 2'd3);
        send_item(mkdlp_pkg::CMD_SCAN, 16'h0080, 32'h0000_0010, 2'd3);
        send_item(mkdlp_pkg::CMD_RD_LONG, 16'h0000, 32'd0, 2'd3);
        tick_now = 32'd13300;
    endtask

    task automatic test_default_timing();
        random_traffic(350);
    endtask

    task automatic test_short_timing();
        mkdlp_pkg::cfg_t c;
        c = '{debounce: 16'd3, tier1: 32'd20, tier2: 32'd40, tier3: 32'd60,
              idle_long: 32'd400, idle_short: 32'd150, key_masks: mkdlp_pkg::KEY_MASKS_RST};
        load_settings(c);
        random_traffic(350);
    endtask

    task automatic test_zero_thresholds();
        mkdlp_pkg::cfg_t c;
        c = '0;
        c.key_masks = {sparse_mask(), sparse_mask(), sparse_mask(), 16'h0000};
        load_settings(c);
        random_traffic(250);
    endtask

    task automatic test_max_thresholds();
        mkdlp_pkg::cfg_t c;
        c = '{debounce: 16'hFFFF, tier1: '1, tier2: '1, tier3: '1,
              idle_long: '1, idle_short: '1,
              key_masks: {sparse_mask(), 16'h0000, sparse_mask(), 16'hFFFF}};
        load_settings(c);
        random_traffic(250);
    endtask

    task automatic test_odd_orderings();
        mkdlp_pkg::cfg_t c;
        c.debounce   = 16'($urandom_range(0, 6));
        c.tier1      = $urandom_range(60, 90);
        c.tier2      = $urandom_range(10, 30);
        c.tier3      = $urandom_range(30, 60);
        c.idle_long  = $urandom_range(100, 200);
        c.idle_short = $urandom_range(300, 600);
        c.key_masks  = {sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask()};
        load_settings(c);
        random_traffic(350);
    endtask

    task automatic test_tick_wrap();
        mkdlp_pkg::cfg_t c;
        c = '{debounce: 16'd8, tier1: 32'd50, tier2: 32'd100, tier3: 32'd200,
              idle_long: 32'd900, idle_short: 32'd300,
              key_masks: {sparse_mask(), sparse_mask(), 16'h0003, 16'h0100}};
        load_settings(c);
        tick_now = 32'hFFFF_FE00;
        random_traffic(350);
    endtask

    initial
    begin
        cfg_now = '{debounce: mkdlp_pkg::DEBOUNCE_RST, tier1: mkdlp_pkg::TIER1_RST,
                    tier2: mkdlp_pkg::TIER2_RST, tier3: mkdlp_pkg::TIER3_RST,
                    idle_long: mkdlp_pkg::IDLE_LONG_RST,
                    idle_short: mkdlp_pkg::IDLE_SHORT_RST,
                    key_masks: mkdlp_pkg::KEY_MASKS_RST};
        for (int k = 0; k < mkdlp_pkg::NUM_KEYS_DEF; k++)
        begin
            key_phase[k]     = mkdlp_pkg::PH_IDLE;
            debounce_mark[k] = '0;
            hold_mark[k]     = '0;
            long_hit[k]      = 1'b0;
            key_step[k]      = mkdlp_pkg::STEP_ONE;
            short_latch[k]   = 1'b0;
            long_latch[k]    = 1'b0;
        end
        action_mark = '0;
        idle_now    = mkdlp_pkg::IDLE_LONG;
        error_now   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        test_default_timing();
        test_short_timing();
        test_zero_thresholds();
        test_max_thresholds();
        test_odd_orderings();
        test_tick_wrap();
        s_tvalid <= 1'b0;
        for (int w = 0; w < 200000 && expected_reports.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
        begin
            $display("%0t ERROR results outstanding, expected 0 actual %0d",
                     $time, expected_reports.size());
            failures++;
        end
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
hdl/mkdlp_pkg.sv
hdl/mkdlp_cfg.sv
hdl/mkdlp_key.sv
hdl/multi_key_debounce_long_press_top.sv
dv/testbench.sv
